// ===== src/terminal_page_break_scanner_core_macros.svh =====
// assertion macros shared by the page break scanner rtl
`ifndef TERMINAL_PAGE_BREAK_SCANNER_CORE_MACROS_SVH
`define TERMINAL_PAGE_BREAK_SCANNER_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TPBS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tpbs assertion failed");

// condition in this cycle implies a result in the next cycle
`define TPBS_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tpbs assertion failed");

`endif

// ===== src/tpbs_pkg.sv =====
// types, character codes and the per-byte classify function of the page break scanner
`timescale 1ns / 1ps

package tpbs_pkg;

    // character codes
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_M   = 8'h6D;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic [8:0] LINE_MAX = 9'd511;
    localparam logic [7:0] PAGE_LENGTH_RESET = 8'd22;

    // stream state carried between bytes
    typedef struct packed {
        logic [7:0] column;
        logic [8:0] line;
        logic       escape;
        logic [7:0] prior0;
        logic [7:0] prior1;
    } tpbs_state_t;

    // one classified byte and the state it leaves
    typedef struct packed {
        tpbs_state_t st;
        logic        brk;
    } tpbs_step_t;

    // one output queue entry
    typedef struct packed {
        logic [7:0] data;
        logic       page_start;
        logic       last;
    } tpbs_entry_t;

    function automatic tpbs_state_t clear_state();
        tpbs_state_t s;
        s.column = 8'd1;
        s.line   = 9'd1;
        s.escape = 1'b0;
        s.prior0 = 8'd0;
        s.prior1 = 8'd0;
        return s;
    endfunction

    function automatic logic [8:0] line_up(logic [8:0] line);
        logic [8:0] r;
        r = (line < LINE_MAX) ? line + 9'd1 : line;
        return r;
    endfunction

    // classify byte c with lookahead nxt
    function automatic tpbs_step_t classify(tpbs_state_t st_in, logic [7:0] c,
                                            logic [7:0] nxt, logic [7:0] page_len,
                                            logic [7:0] cols);
        tpbs_step_t r;
        tpbs_state_t s;
        logic brk;
        s   = st_in;
        brk = (page_len != 8'd0) && (s.line > {1'b0, page_len});
        if (brk)
        begin
            s.column = 8'd1;
            s.line   = 9'd1;
            s.escape = 1'b0;
        end
        if (c == CH_ESC && !s.escape)
        begin
            s.escape = 1'b1;
        end
        else if (!s.escape && c == CH_AMP && nxt != CH_AMP)
        begin
            s.escape = 1'b1;
        end
        else if (c == CH_M && s.escape)
        begin
            s.escape = 1'b0;
        end
        else if (s.escape && st_in.prior1 == CH_AMP)
        begin
            s.escape = 1'b0;
        end
        else if (!s.escape)
        begin
            if (c == CH_CR)
            begin
                s.column = 8'd1;
            end
            else if (c == CH_LF)
            begin
                s.line = line_up(s.line);
            end
            else if (s.column > cols)
            begin
                s.column = 8'd1;
                s.line   = line_up(s.line);
            end
            else
            begin
                s.column = s.column + 8'd1;
            end
        end
        s.prior1 = st_in.prior0;
        s.prior0 = c;
        r.st  = s;
        r.brk = brk;
        return r;
    endfunction

endpackage

// ===== src/terminal_page_break_scanner_core.sv =====
// top level of the terminal page break scanner: classify logic and output queue
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid in_ready in_byte in_last    | to core
//  out     | out_valid out_ready out_byte         | from core
//          | page_start out_last                  |
//  cfg     | cfg_valid cfg_ready cfg_data         | to core
//
// one input transfer per cycle while in_ready is high. a byte not marked last is held and
// classified, with the next byte as lookahead, when that byte is taken; its result then
// enters the four-entry output queue. a last byte is pushed at once, with any held byte.
// in_ready drops while the queue holds three or more entries (out_ready stalls).
// reset clears the stream state, empties the queue and sets page_length to 22.
`timescale 1ns / 1ps

`include "terminal_page_break_scanner_core_macros.svh"

module terminal_page_break_scanner_core #(
    parameter int PAGE_COLUMNS = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       page_start,
    output logic       out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam logic [7:0] COLS = 8'(PAGE_COLUMNS);

    tpbs_pkg::tpbs_state_t st_reg, st_next;
    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic [7:0]            page_length_reg;

    tpbs_pkg::tpbs_entry_t queue_reg [4];
    logic [1:0]            wr_ptr_reg, wr_ptr_next;
    logic [1:0]            rd_ptr_reg, rd_ptr_next;
    logic [2:0]            count_reg, count_next;

    logic                  in_fire, out_fire;
    tpbs_pkg::tpbs_step_t  step_held, step_last;
    tpbs_pkg::tpbs_state_t st_mid;
    tpbs_pkg::tpbs_entry_t entry_a, entry_b;
    logic                  push_a, push_b;

    // handshakes
    assign in_ready  = (count_reg < 3'd3);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_fire  = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    // queue head drives the result ports
    assign out_byte   = queue_reg[rd_ptr_reg].data;
    assign page_start = queue_reg[rd_ptr_reg].page_start;
    assign out_last   = queue_reg[rd_ptr_reg].last;

    // held byte classified with the new byte as lookahead, then the last byte if marked
    always_comb
    begin
        step_held = tpbs_pkg::classify(st_reg, held_byte_reg, in_byte,
                                       page_length_reg, COLS);
        st_mid    = held_valid_reg ? step_held.st : st_reg;
        step_last = tpbs_pkg::classify(st_mid, in_byte, 8'd0, page_length_reg, COLS);
    end

    // next stream state and queue writes
    always_comb
    begin
        st_next         = st_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        push_a          = 1'b0;
        push_b          = 1'b0;
        entry_a.data       = in_byte;
        entry_a.page_start = step_last.brk;
        entry_a.last       = 1'b1;
        entry_b.data       = in_byte;
        entry_b.page_start = step_last.brk;
        entry_b.last       = 1'b1;
        if (held_valid_reg)
        begin
            entry_a.data       = held_byte_reg;
            entry_a.page_start = step_held.brk;
            entry_a.last       = 1'b0;
        end
        if (in_fire)
        begin
            push_a = held_valid_reg || in_last;
            push_b = held_valid_reg && in_last;
            if (in_last)
            begin
                st_next         = tpbs_pkg::clear_state();
                held_byte_next  = 8'd0;
                held_valid_next = 1'b0;
            end
            else
            begin
                st_next         = st_mid;
                held_byte_next  = in_byte;
                held_valid_next = 1'b1;
            end
        end
        wr_ptr_next = wr_ptr_reg + {1'b0, push_a} + {1'b0, push_b};
        rd_ptr_next = rd_ptr_reg + {1'b0, out_fire};
        count_next  = count_reg + {2'b0, push_a} + {2'b0, push_b} - {2'b0, out_fire};
    end

    // control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= tpbs_pkg::clear_state();
            held_byte_reg   <= 8'd0;
            held_valid_reg  <= 1'b0;
            page_length_reg <= tpbs_pkg::PAGE_LENGTH_RESET;
            wr_ptr_reg      <= 2'd0;
            rd_ptr_reg      <= 2'd0;
            count_reg       <= 3'd0;
        end
        else
        begin
            st_reg         <= st_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                page_length_reg <= cfg_data;
            end
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            queue_reg[wr_ptr_reg] <= entry_a;
        end
        if (push_b)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= entry_b;
        end
    end

    // checks
    `TPBS_ASSERT_ALWAYS(a_count_bound, count_reg <= 3'd4)
    `TPBS_ASSERT_NEXT(a_last_clears_hold, in_fire && in_last, !held_valid_reg)
    `TPBS_ASSERT_NEXT(a_double_push, in_fire && in_last && held_valid_reg && !out_fire,
        count_reg == $past(count_reg) + 3'd2)
    `TPBS_ASSERT_ALWAYS(a_idle_state_clear,
        held_valid_reg || (st_reg.line == 9'd1 && st_reg.column == 8'd1 && !st_reg.escape))

endmodule
